// ===== sv/joystick_wheel_key_selector_defines.svh =====
// ----------------------------------------------------------------------------
// Joystick wheel key selector assertion macros
// Shared property shorthands for the port checker. Each expects clk and
// arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_WHEEL_KEY_SELECTOR_DEFINES_SVH
`define JOYSTICK_WHEEL_KEY_SELECTOR_DEFINES_SVH

// same-cycle implication
`define JWKS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JWKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/jwks_pkg.sv =====
// ----------------------------------------------------------------------------
// jwks_pkg
// Types, widths, sector boundary coefficients and key tables for the
// joystick wheel key selector.
// ----------------------------------------------------------------------------
package jwks_pkg;

	localparam int ADC_BITS   = 12;
	localparam int DZ_W       = 12;
	localparam int DEB_W      = 16;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int DIFF_W = ADC_BITS + 1;       // centered sample, signed
	localparam int MAG_W  = 2 * ADC_BITS + 1;   // dx^2 + dy^2
	localparam int DZSQ_W = 2 * DZ_W;
	localparam int COEF_W = 17;                 // Q1.15 incl. +-32768
	localparam int PROD_W = DIFF_W + COEF_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic [DZ_W-1:0]     DZ_RESET     = DZ_W'(800);
	localparam logic [ADC_BITS-1:0] CENTER_RESET = ADC_BITS'(2048);
	localparam logic [DEB_W-1:0]    DEB_RESET    = DEB_W'(150);

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADZONE = 2'd0,
		REG_CENTER   = 2'd1,
		REG_DEBOUNCE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_PRESS  = 1'b1
	} op_t;

	localparam logic       STICK_ONE    = 1'b0;
	localparam logic [1:0] WHEEL_DIGITS = 2'd1;  // stick one: ten sectors
	localparam logic [1:0] WHEEL_LAST   = 2'd2;

	// boundary cos/sin magnitudes, Q1.15
	localparam logic signed [PROD_W-1:0] K8_A  = PROD_W'(30274);
	localparam logic signed [PROD_W-1:0] K8_B  = PROD_W'(12540);
	localparam logic signed [PROD_W-1:0] K10_A = PROD_W'(31164);
	localparam logic signed [PROD_W-1:0] K10_B = PROD_W'(19261);
	localparam logic signed [PROD_W-1:0] K10_C = PROD_W'(10126);
	localparam logic signed [PROD_W-1:0] K10_D = PROD_W'(26510);
	localparam logic signed [PROD_W-1:0] K_ONE = PROD_W'(32768);

	typedef struct packed {
		logic                  opcode;
		logic                  stick_select;
		logic [ADC_BITS-1:0]   x_raw;
		logic [ADC_BITS-1:0]   y_raw;
		logic [TIME_W-1:0]     now_ms;
	} item_t;

	typedef struct packed {
		logic       key_valid;
		logic [7:0] key_code;
		logic [3:0] direction;
		logic [1:0] wheel_index;
		logic       wheel_changed;
	} result_t;

	localparam logic [7:0] KEY_ENTER     = 8'h28;
	localparam logic [7:0] KEY_BKSP      = 8'hB2;
	localparam logic [7:0] KEY_DEL       = 8'hD4;
	localparam logic [7:0] KEY_INS       = 8'hD1;
	localparam logic [7:0] KEY_ORDINAL   = 8'hBA;
	localparam logic [7:0] KEY_INV_EXCL  = 8'hA1;

	// [stick][wheel][sector]
	localparam logic [7:0] KEY_TABLE [2][3][10] = '{
		'{
			'{8'h61, 8'h65, 8'h69, 8'h6F, 8'h75, KEY_ENTER, KEY_BKSP,
				KEY_DEL, 8'h00, 8'h00},
			'{8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39},
			'{8'h3C, 8'h2C, 8'h2E, 8'h2D, 8'h2B, KEY_ORDINAL, 8'h3F,
				KEY_INV_EXCL, 8'h00, 8'h00}
		},
		'{
			'{8'h62, 8'h63, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h00, 8'h00},
			'{8'h6C, 8'h6D, 8'h6E, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h00, 8'h00},
			'{8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, KEY_INS, KEY_BKSP,
				KEY_DEL, 8'h00, 8'h00}
		}
	};

endpackage

// ===== sv/joystick_wheel_key_selector.sv =====
// ----------------------------------------------------------------------------
// joystick_wheel_key_selector
// Turns stick samples and wheel-button presses of two sticks into key codes.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | word
//  ---------+----------------------------+--------------------------------
//  cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//  item     | item_valid / item_stall    | item   (jwks_pkg::item_t)
//  result   | result_valid / result_stall| result (jwks_pkg::result_t)
//
//  One word in and one word out every cycle while no stall holds; each
//  word passes the input reg, then the product reg, then the result reg.
//  The product stage feeds all sector compares; state (wheels, press times,
//  arm flags) is read and written only at the product-to-result step, so
//  back-to-back words on the same stick see each other's updates.
//  result_stall backs up through the stages; item_stall rises only when
//  every stage is full. cfg_ready is always high; the deadzone square is
//  re-registered from deadzone_q in the cycle after a deadzone write.
//  arst_n clears valids, config to defaults, wheels to 0, arms to set.
// ----------------------------------------------------------------------------
module joystick_wheel_key_selector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [jwks_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jwks_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  jwks_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output jwks_pkg::result_t                   result
);
	import jwks_pkg::*;

	// ---------------- configuration ----------------
	logic [DZ_W-1:0]     deadzone_q;
	logic [ADC_BITS-1:0] center_q;
	logic [DEB_W-1:0]    debounce_q;
	logic [DZSQ_W-1:0]   dz_sq_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= DZ_RESET;
			center_q   <= CENTER_RESET;
			debounce_q <= DEB_RESET;
			dz_sq_q    <= DZSQ_W'(DZSQ_W'(DZ_RESET) * DZSQ_W'(DZ_RESET));
		end else begin
			dz_sq_q <= DZSQ_W'(deadzone_q) * DZSQ_W'(deadzone_q);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEADZONE: deadzone_q <= cfg_data[DZ_W-1:0];
					REG_CENTER:   center_q   <= cfg_data[ADC_BITS-1:0];
					REG_DEBOUNCE: debounce_q <= cfg_data[DEB_W-1:0];
					default: ;   // unmapped index: ignored
				endcase
			end
		end
	end

	// ---------------- flow control ----------------
	logic v_s1, v_s2, out_valid_q;
	logic out_ready, s2_ready, s1_ready, fire_s2;

	assign out_ready  = !out_valid_q || !result_stall;
	assign s2_ready   = !v_s2 || out_ready;
	assign s1_ready   = !v_s1 || s2_ready;
	assign fire_s2    = v_s2 && out_ready;
	assign item_stall = !s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready)  v_s1        <= item_valid;
			if (s2_ready)  v_s2        <= v_s1;
			if (out_ready) out_valid_q <= v_s2;
		end
	end

	// ---------------- stage 1: center, square, products ----------------
	item_t item_s1;

	always_ff @(posedge clk) begin
		if (s1_ready) item_s1 <= item;
	end

	logic signed [DIFF_W-1:0]   dx_c, dy_c;
	logic signed [2*DIFF_W-1:0] dxx_c, dyy_c;
	logic [MAG_W-1:0]           mag_c;
	logic                       upper_c, zero_c;
	logic signed [PROD_W-1:0]   pa_c, pb_c, pc_c, pd_c;         // eight-sector set
	logic signed [PROD_W-1:0]   pe_c, pf_c, pg_c, ph_c, pi_c;   // ten-sector set

	assign dx_c  = $signed({1'b0, item_s1.x_raw}) - $signed({1'b0, center_q});
	assign dy_c  = $signed({1'b0, item_s1.y_raw}) - $signed({1'b0, center_q});
	assign dxx_c = dx_c * dx_c;
	assign dyy_c = dy_c * dy_c;
	assign mag_c = MAG_W'(dxx_c) + MAG_W'(dyy_c);

	// upper half plane: dy > 0, or on the positive x axis
	assign zero_c  = (dx_c == '0) && (dy_c == '0);
	assign upper_c = (!dy_c[DIFF_W-1] && (dy_c != '0)) ||
		((dy_c == '0) && !dx_c[DIFF_W-1] && (dx_c != '0));

	assign pa_c = PROD_W'(dy_c) * K8_A;
	assign pb_c = PROD_W'(dy_c) * K8_B;
	assign pc_c = PROD_W'(dx_c) * K8_B;
	assign pd_c = PROD_W'(dx_c) * K8_A;
	assign pe_c = PROD_W'(dy_c) * K10_A;
	assign pf_c = PROD_W'(dy_c) * K10_B;
	assign pg_c = PROD_W'(dx_c) * K10_C;
	assign ph_c = PROD_W'(dx_c) * K10_D;
	assign pi_c = PROD_W'(dx_c) * K_ONE;

	// ---------------- stage 2 registers ----------------
	logic                     op_s2, st_s2, upper_s2, zero_s2;
	logic [TIME_W-1:0]        now_s2;
	logic [MAG_W-1:0]         mag_s2;
	logic signed [PROD_W-1:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [PROD_W-1:0] pe_s2, pf_s2, pg_s2, ph_s2, pi_s2;

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			op_s2    <= item_s1.opcode;
			st_s2    <= item_s1.stick_select;
			now_s2   <= item_s1.now_ms;
			mag_s2   <= mag_c;
			upper_s2 <= upper_c;
			zero_s2  <= zero_c;
			pa_s2    <= pa_c;
			pb_s2    <= pb_c;
			pc_s2    <= pc_c;
			pd_s2    <= pd_c;
			pe_s2    <= pe_c;
			pf_s2    <= pf_c;
			pg_s2    <= pg_c;
			ph_s2    <= ph_c;
			pi_s2    <= pi_c;
		end
	end

	// ---------------- stage 2: boundary tests, sector ----------------
	logic signed [SUM_W-1:0] s8 [8];
	logic signed [SUM_W-1:0] s10 [10];
	logic [7:0]              reach8;
	logic [9:0]              reach10;
	logic [3:0]              cnt8, cnt10, sec8, sec10;

	// dy*cos - dx*sin for each boundary, built from the shared products
	assign s8[0] =  SUM_W'(pa_s2) - SUM_W'(pc_s2);
	assign s8[1] =  SUM_W'(pb_s2) - SUM_W'(pd_s2);
	assign s8[2] = -SUM_W'(pb_s2) - SUM_W'(pd_s2);
	assign s8[3] = -SUM_W'(pa_s2) - SUM_W'(pc_s2);
	assign s8[4] = -SUM_W'(pa_s2) + SUM_W'(pc_s2);
	assign s8[5] = -SUM_W'(pb_s2) + SUM_W'(pd_s2);
	assign s8[6] =  SUM_W'(pb_s2) + SUM_W'(pd_s2);
	assign s8[7] =  SUM_W'(pa_s2) + SUM_W'(pc_s2);

	assign s10[0] =  SUM_W'(pe_s2) - SUM_W'(pg_s2);
	assign s10[1] =  SUM_W'(pf_s2) - SUM_W'(ph_s2);
	assign s10[2] = -SUM_W'(pi_s2);
	assign s10[3] = -SUM_W'(pf_s2) - SUM_W'(ph_s2);
	assign s10[4] = -SUM_W'(pe_s2) - SUM_W'(pg_s2);
	assign s10[5] = -SUM_W'(pe_s2) + SUM_W'(pg_s2);
	assign s10[6] = -SUM_W'(pf_s2) + SUM_W'(ph_s2);
	assign s10[7] =  SUM_W'(pi_s2);
	assign s10[8] =  SUM_W'(pf_s2) + SUM_W'(ph_s2);
	assign s10[9] =  SUM_W'(pe_s2) + SUM_W'(pg_s2);

	// first half of each set sits in the upper half plane
	always_comb begin
		cnt8  = '0;
		cnt10 = '0;
		for (int j = 0; j < 8; j++) begin
			if (j < 4) reach8[j] = !upper_s2 || !s8[j][SUM_W-1];
			else       reach8[j] = !upper_s2 && !s8[j][SUM_W-1];
			cnt8 = cnt8 + 4'(reach8[j]);
		end
		for (int j = 0; j < 10; j++) begin
			if (j < 5) reach10[j] = !upper_s2 || !s10[j][SUM_W-1];
			else       reach10[j] = !upper_s2 && !s10[j][SUM_W-1];
			cnt10 = cnt10 + 4'(reach10[j]);
		end
	end

	// all boundaries reached wraps to sector 0
	assign sec8  = (cnt8 == 4'd8) ? 4'd0 : cnt8;
	assign sec10 = (cnt10 == 4'd10) ? 4'd0 : cnt10;

	// ---------------- per-stick state ----------------
	logic [1:0]        wheel_q [2];
	logic [TIME_W-1:0] last_q [2];
	logic              armed_q [2];

	logic [1:0]        w_cur, w_next;
	logic              armed_cur, press_ok, outside, ten;
	logic [TIME_W-1:0] elapsed;
	logic [3:0]        dir_c;
	result_t           res_c;

	assign w_cur     = wheel_q[st_s2];
	assign armed_cur = armed_q[st_s2];
	assign elapsed   = now_s2 - last_q[st_s2];   // wraps mod 2^32
	assign press_ok  = elapsed > TIME_W'(debounce_q);
	assign w_next    = (w_cur == WHEEL_LAST) ? 2'd0 : w_cur + 2'd1;
	assign outside   = mag_s2 >= MAG_W'(dz_sq_q);
	assign ten       = (st_s2 == STICK_ONE) && (w_cur == WHEEL_DIGITS);
	assign dir_c     = zero_s2 ? 4'd0 : (ten ? sec10 : sec8);

	always_comb begin
		res_c             = '0;
		res_c.wheel_index = w_cur;
		if (op_s2 == OP_PRESS) begin
			if (press_ok) begin
				res_c.wheel_changed = 1'b1;
				res_c.wheel_index   = w_next;
			end
		end else if (outside) begin
			res_c.direction = dir_c;
			if (armed_cur) begin
				res_c.key_valid = 1'b1;
				res_c.key_code  = KEY_TABLE[st_s2][w_cur][dir_c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 2; s++) begin
				wheel_q[s] <= 2'd0;
				last_q[s]  <= '0;
				armed_q[s] <= 1'b1;
			end
		end else if (fire_s2) begin
			if (op_s2 == OP_PRESS) begin
				if (press_ok) begin
					wheel_q[st_s2] <= w_next;
					last_q[st_s2]  <= now_s2;
				end
			end else if (outside) begin
				if (armed_cur) armed_q[st_s2] <= 1'b0;   // one key per excursion
			end else begin
				armed_q[st_s2] <= 1'b1;                  // back in the deadzone
			end
		end
	end

	// ---------------- result register ----------------
	result_t result_q;

	always_ff @(posedge clk) begin
		if (fire_s2) result_q <= res_c;
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

endmodule

// ===== sv/jwks_checker.sv =====
// ----------------------------------------------------------------------------
// jwks_checker
// Port-level checks for the joystick wheel key selector.
// ----------------------------------------------------------------------------
`include "joystick_wheel_key_selector_defines.svh"

module jwks_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input jwks_pkg::result_t result
);
	import jwks_pkg::*;

	`JWKS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid, "result dropped while stalled")
	`JWKS_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result), "stalled result changed")
	`JWKS_ASSERT_NOW(a_no_key_zero_code, result_valid && !result.key_valid, result.key_code == 8'd0, "code without key")
	`JWKS_ASSERT_NOW(a_press_no_key, result_valid && result.wheel_changed, !result.key_valid && (result.direction == 4'd0), "press word carries a key")
	`JWKS_ASSERT_NOW(a_wheel_range, result_valid, (result.wheel_index != 2'd3) && (result.direction <= 4'd9), "wheel or sector out of range")

endmodule

bind joystick_wheel_key_selector jwks_checker u_jwks_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
